FILE: hdl/ladder_button_debounce_longpress_macros.svh
// ----------------------------------------------------------------------------
// ladder_button_debounce_longpress_macros
// Assertion macros for the ladder button decoder.
// ----------------------------------------------------------------------------
`ifndef LADDER_BUTTON_DEBOUNCE_LONGPRESS_MACROS_SVH
`define LADDER_BUTTON_DEBOUNCE_LONGPRESS_MACROS_SVH

// same-cycle implication, disabled in reset
`define LBD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ladder button check failed");

// next-cycle implication, disabled in reset
`define LBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ladder button check failed");

`endif

FILE: hdl/lbd_pkg.sv
// ----------------------------------------------------------------------------
// lbd_pkg
// Shared types and constants of the ladder button decoder.
// ----------------------------------------------------------------------------
package lbd_pkg;

   localparam int TICK_BITS_DEF  = 32;
   localparam int MV_BITS_DEF    = 12;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;
   localparam int LEVEL_BITS     = 12;
   localparam int TIME_BITS      = 16;
   localparam int BTN_BITS       = 3;
   localparam int TOL_MV         = 220;

   typedef logic [BTN_BITS-1:0]       btn_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   typedef logic [LEVEL_BITS-1:0]     level_type;
   typedef logic [TIME_BITS-1:0]      time_type;

   localparam btn_type BTN_NONE = 3'd0;
   localparam btn_type BTN_A    = 3'd1;
   localparam btn_type BTN_B    = 3'd2;
   localparam btn_type BTN_C    = 3'd3;
   localparam btn_type BTN_D    = 3'd4;
   localparam btn_type BTN_AB   = 3'd5;
   localparam btn_type BTN_BC   = 3'd6;

   localparam csr_index_type CSR_LEVEL_A  = 3'd0;
   localparam csr_index_type CSR_LEVEL_AB = 3'd1;
   localparam csr_index_type CSR_LEVEL_B  = 3'd2;
   localparam csr_index_type CSR_LEVEL_BC = 3'd3;
   localparam csr_index_type CSR_LEVEL_C  = 3'd4;
   localparam csr_index_type CSR_LEVEL_D  = 3'd5;
   localparam csr_index_type CSR_SETTLE   = 3'd6;
   localparam csr_index_type CSR_HOLD     = 3'd7;

   localparam level_type RST_LEVEL_A  = 12'd825;
   localparam level_type RST_LEVEL_AB = 12'd1100;
   localparam level_type RST_LEVEL_B  = 12'd1650;
   localparam level_type RST_LEVEL_BC = 12'd2200;
   localparam level_type RST_LEVEL_C  = 12'd2475;
   localparam level_type RST_LEVEL_D  = 12'd3300;
   localparam time_type  RST_SETTLE   = 16'd25;
   localparam time_type  RST_HOLD     = 16'd1200;

   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_PRESS = 2'd1,
      EV_LONG  = 2'd2
   } event_kind_type;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = 1;

endpackage

FILE: hdl/ladder_button_debounce_longpress.sv
// an accepted request is written into the queue, then popped by the back end into the result register
// throughput: one request per cycle while req_stall is low; the debounce state update in the back end sets this
// a two-entry queue lets the decode side run on while a result waits under stall
// reset (synchronous, active high) restores the level and timing registers and clears
// the accepted and candidate buttons, their ticks, the long-press flag, the result valid and the queue
// ----------------------------------------------------------------------------
// ladder_button_debounce_longpress
// Resistor-ladder button decoder with debounce and long-press events.
// ----------------------------------------------------------------------------
module ladder_button_debounce_longpress #(
   parameter int TICK_BITS = lbd_pkg::TICK_BITS_DEF,
   parameter int MV_BITS   = lbd_pkg::MV_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  lbd_pkg::csr_index_type            csr_index,
   input  logic [lbd_pkg::CSR_DATA_BITS-1:0] csr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [MV_BITS-1:0]                req_level_mv,
   input  logic [TICK_BITS-1:0]              req_now_tick,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_event_kind,
   output logic [lbd_pkg::BTN_BITS-1:0]      rsp_button,
   output logic [TICK_BITS-1:0]              rsp_event_tick,
   output logic                              rsp_activity
);
   import lbd_pkg::*;

   localparam int ENTRY_BITS = BTN_BITS + TICK_BITS;

   btn_type               dec_button;
   logic                  q_full;
   logic                  q_not_empty;
   logic                  q_pop;
   logic                  q_push;
   logic [ENTRY_BITS-1:0] q_head;
   event_kind_type        kind;

   lbd_front #(.MV_BITS(MV_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .level_mv  (req_level_mv),
      .button    (dec_button)
   );

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   lbd_queue #(.WIDTH(ENTRY_BITS)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({dec_button, req_now_tick}),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_data (q_head)
   );

   lbd_back #(.TICK_BITS(TICK_BITS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .head_valid     (q_not_empty),
      .head_button    (q_head[ENTRY_BITS-1:TICK_BITS]),
      .head_tick      (q_head[TICK_BITS-1:0]),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_event_kind (kind),
      .rsp_button     (rsp_button),
      .rsp_event_tick (rsp_event_tick),
      .rsp_activity   (rsp_activity)
   );

   assign rsp_event_kind = kind;

endmodule

FILE: hdl/lbd_front.sv
// ----------------------------------------------------------------------------
// lbd_front
// Level registers and nearest-level decode of one ladder sample.
// ----------------------------------------------------------------------------
module lbd_front #(
   parameter int MV_BITS = lbd_pkg::MV_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  lbd_pkg::csr_index_type        csr_index,
   input  logic [lbd_pkg::CSR_DATA_BITS-1:0] csr_data,
   input  logic [MV_BITS-1:0]            level_mv,
   output lbd_pkg::btn_type              button
);
   import lbd_pkg::*;

   level_type level_a_ff, level_ab_ff, level_b_ff, level_bc_ff, level_c_ff, level_d_ff;

   logic [MV_BITS-1:0] target [6];
   btn_type            code   [6];
   logic [MV_BITS-1:0] delta;
   logic [MV_BITS-1:0] best_dist;
   logic               found;
   btn_type            near_btn;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_a_ff  <= RST_LEVEL_A;
         level_ab_ff <= RST_LEVEL_AB;
         level_b_ff  <= RST_LEVEL_B;
         level_bc_ff <= RST_LEVEL_BC;
         level_c_ff  <= RST_LEVEL_C;
         level_d_ff  <= RST_LEVEL_D;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LEVEL_A:  level_a_ff  <= csr_data[LEVEL_BITS-1:0];
            CSR_LEVEL_AB: level_ab_ff <= csr_data[LEVEL_BITS-1:0];
            CSR_LEVEL_B:  level_b_ff  <= csr_data[LEVEL_BITS-1:0];
            CSR_LEVEL_BC: level_bc_ff <= csr_data[LEVEL_BITS-1:0];
            CSR_LEVEL_C:  level_c_ff  <= csr_data[LEVEL_BITS-1:0];
            CSR_LEVEL_D:  level_d_ff  <= csr_data[LEVEL_BITS-1:0];
            default: ;
         endcase
      end
   end

   // check order sets the tie break: first within tolerance and closest wins
   always_comb begin
      target[0] = MV_BITS'(level_ab_ff); code[0] = BTN_AB;
      target[1] = MV_BITS'(level_bc_ff); code[1] = BTN_BC;
      target[2] = MV_BITS'(level_d_ff);  code[2] = BTN_D;
      target[3] = MV_BITS'(level_c_ff);  code[3] = BTN_C;
      target[4] = MV_BITS'(level_b_ff);  code[4] = BTN_B;
      target[5] = MV_BITS'(level_a_ff);  code[5] = BTN_A;
   end

   always_comb begin
      found     = 1'b0;
      best_dist = '0;
      near_btn  = BTN_NONE;
      delta     = '0;
      for (int i = 0; i < 6; i++) begin
         delta = (target[i] >= level_mv) ? (target[i] - level_mv) : (level_mv - target[i]);
         if (delta <= MV_BITS'(TOL_MV) && (!found || delta < best_dist)) begin
            found     = 1'b1;
            best_dist = delta;
            near_btn  = code[i];
         end
      end
   end

   assign button = near_btn;

endmodule

FILE: hdl/lbd_queue.sv
// ----------------------------------------------------------------------------
// lbd_queue
// Two-entry queue between the decode front and the debounce back end.
// ----------------------------------------------------------------------------
module lbd_queue #(
   parameter int WIDTH = 35
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output logic [WIDTH-1:0] head_data
);
   import lbd_pkg::*;

   logic [WIDTH-1:0]     entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + {{QPTR_BITS{1'b0}}, push} - {{QPTR_BITS{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_data = entry_ff[rd_ptr_ff];

endmodule

FILE: hdl/lbd_back.sv
// ----------------------------------------------------------------------------
// lbd_back
// Debounce, press and long-press detection, and the result register.
// ----------------------------------------------------------------------------
module lbd_back #(
   parameter int TICK_BITS = lbd_pkg::TICK_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  lbd_pkg::csr_index_type            csr_index,
   input  logic [lbd_pkg::CSR_DATA_BITS-1:0] csr_data,
   input  logic                              head_valid,
   input  lbd_pkg::btn_type                  head_button,
   input  logic [TICK_BITS-1:0]              head_tick,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output lbd_pkg::event_kind_type           rsp_event_kind,
   output lbd_pkg::btn_type                  rsp_button,
   output logic [TICK_BITS-1:0]              rsp_event_tick,
   output logic                              rsp_activity
);
   import lbd_pkg::*;

`include "ladder_button_debounce_longpress_macros.svh"

   time_type settle_ff, hold_ff;

   btn_type              acc_btn_ff, acc_btn_in;
   logic [TICK_BITS-1:0] acc_tick_ff, acc_tick_in;
   logic                 long_ff, long_in;
   btn_type              cand_btn_ff, cand_btn_in;
   logic [TICK_BITS-1:0] cand_tick_ff, cand_tick_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   event_kind_type       kind_ff, kind_in;
   btn_type              btn_ff, btn_in;
   logic [TICK_BITS-1:0] tick_ff, tick_in;
   logic                 act_ff, act_in;

   logic                 cand_new;
   logic                 settled;
   logic                 changed;
   logic                 held;
   btn_type              cur;

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= RST_SETTLE;
         hold_ff   <= RST_HOLD;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SETTLE: settle_ff <= csr_data[TIME_BITS-1:0];
            CSR_HOLD:   hold_ff   <= csr_data[TIME_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign pop = head_valid && (!rsp_valid_ff || !rsp_stall);

   // tick differences wrap at the counter width
   always_comb begin
      cand_new = (head_button != cand_btn_ff);
      settled  = !cand_new && ((head_tick - cand_tick_ff) >= TICK_BITS'(settle_ff));
      cur      = settled ? head_button : acc_btn_ff;
      changed  = (cur != acc_btn_ff);
      held     = !changed && (acc_btn_ff != BTN_NONE) && !long_ff
                 && ((head_tick - acc_tick_ff) >= TICK_BITS'(hold_ff));
   end

   always_comb begin
      acc_btn_in   = acc_btn_ff;
      acc_tick_in  = acc_tick_ff;
      long_in      = long_ff;
      cand_btn_in  = cand_btn_ff;
      cand_tick_in = cand_tick_ff;
      kind_in      = kind_ff;
      btn_in       = btn_ff;
      tick_in      = tick_ff;
      act_in       = act_ff;
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
         if (cand_new) begin
            cand_btn_in  = head_button;
            cand_tick_in = head_tick;
         end
         kind_in = EV_NONE;
         act_in  = 1'b0;
         if (changed) begin
            act_in      = 1'b1;
            acc_btn_in  = cur;
            acc_tick_in = head_tick;
            long_in     = 1'b0;
            if (cur != BTN_NONE) begin
               kind_in = EV_PRESS;
            end
         end else if (held) begin
            long_in = 1'b1;
            kind_in = EV_LONG;
         end
         btn_in  = cur;
         tick_in = head_tick;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_btn_ff   <= BTN_NONE;
         acc_tick_ff  <= '0;
         long_ff      <= 1'b0;
         cand_btn_ff  <= BTN_NONE;
         cand_tick_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_btn_ff   <= acc_btn_in;
         acc_tick_ff  <= acc_tick_in;
         long_ff      <= long_in;
         cand_btn_ff  <= cand_btn_in;
         cand_tick_ff <= cand_tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      btn_ff  <= btn_in;
      tick_ff <= tick_in;
      act_ff  <= act_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_kind = kind_ff;
   assign rsp_button     = btn_ff;
   assign rsp_event_tick = tick_ff;
   assign rsp_activity   = act_ff;

   `LBD_ASSERT_SAME(a_press_is_activity, clock, reset, rsp_valid_ff && kind_ff == EV_PRESS, act_ff && btn_ff != BTN_NONE)
   `LBD_ASSERT_SAME(a_long_no_activity, clock, reset, rsp_valid_ff && kind_ff == EV_LONG, !act_ff && btn_ff != BTN_NONE)
   `LBD_ASSERT_NEXT(a_change_clears_long, clock, reset, pop && changed, !long_ff && acc_tick_ff == $past(head_tick))
   `LBD_ASSERT_SAME(a_long_needs_button, clock, reset, long_ff, acc_btn_ff != BTN_NONE)

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the ladder button decoder. Voltage samples with tick stamps go
// in under random sender bursts and receiver stalls; a local debounce and
// long-press model or a typed row predicts every event record, and each record
// coming out is compared field by field, in order, with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
   import lbd_pkg::*;

   localparam int TICKW        = TICK_BITS_DEF;
   localparam int MVW          = MV_BITS_DEF;
   localparam int REPORT_LIMIT = 10;
   localparam int PHASE_ITEMS  = 145;

   typedef logic [TICKW-1:0] tick_type;

   typedef struct packed {
      event_kind_type kind;
      btn_type        button;
      tick_type       tick;
      logic           activity;
   } button_event_type;

   typedef struct {
      int             level;
      tick_type       tick;
      logic           typed;
      event_kind_type kind;
      btn_type        button;
      logic           activity;
   } sample_row_type;

   typedef enum int {
      SET_RESET_LEVELS,
      SET_RAIL_LEVELS,
      SET_LONGEST_TIMES,
      SET_EVEN_SPACING,
      SET_RANDOM
   } ladder_setting_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_we = 1'b0;
   csr_index_type            csr_index = CSR_LEVEL_A;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [MVW-1:0]           req_level_mv = '0;
   tick_type                 req_now_tick = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [1:0]               rsp_event_kind;
   btn_type                  rsp_button;
   tick_type                 rsp_event_tick;
   logic                     rsp_activity;

   // typed-in expectation that travels with a directed request
   logic                     req_typed = 1'b0;
   button_event_type         req_typed_event = '0;

   // debounce model state and its copy of the registers
   level_type        ladder_mv [6];
   time_type         settle_time;
   time_type         hold_time;
   btn_type          stable_btn;
   tick_type         stable_since;
   logic             long_sent;
   btn_type          trial_btn;
   tick_type         trial_since;
   button_event_type event_queue [$];

   int mismatches = 0;
   int samples_sent = 0;
   int presses = 0;
   int long_presses = 0;
   int releases = 0;
   int settings_used = 1;
   int burst_left = 0;
   logic [9:0] stall_phase = '0;

   ladder_setting_type phase_plan [8] = '{SET_EVEN_SPACING, SET_RAIL_LEVELS, SET_RANDOM,
      SET_LONGEST_TIMES, SET_RESET_LEVELS, SET_RANDOM, SET_EVEN_SPACING, SET_RANDOM};

   // reset registers: first rows read straight off the debounce rules
   sample_row_type opening_rows [24] = '{
      '{0,    32'd0,          1'b1, EV_NONE,  BTN_NONE, 1'b0},
      '{825,  32'd10,         1'b1, EV_NONE,  BTN_NONE, 1'b0},
      '{825,  32'd35,         1'b1, EV_PRESS, BTN_A,    1'b1},
      '{825,  32'd1234,       1'b1, EV_NONE,  BTN_A,    1'b0},
      '{825,  32'd1235,       1'b1, EV_LONG,  BTN_A,    1'b0},
      '{825,  32'd5000,       1'b1, EV_NONE,  BTN_A,    1'b0},
      '{4095, 32'd5001,       1'b1, EV_NONE,  BTN_A,    1'b0},
      '{4095, 32'd5026,       1'b1, EV_NONE,  BTN_NONE, 1'b1},
      '{1320, 32'd6000,       1'b0, EV_NONE,  BTN_NONE, 1'b0},
      '{1320, 32'd6100,       1'b0, EV_NONE,  BTN_NONE, 1'b0},
      '{1321, 32'd6200,       1'b0, EV_NONE,  BTN_NONE, 1'b0},
      '{963,  32'd6300,       1'b0, EV_NONE,  BTN_NONE, 1'b0},
      '{962,  32'd6400,       1'b0, EV_NONE,  BTN_NONE, 1'b0},
      '{3300, 32'hFFFF_FFF0,  1'b0, EV_NONE,  BTN_NONE, 1'b0},
      '{3300, 32'h0000_0009,  1'b0, EV_NONE,  BTN_NONE, 1'b0},
      '{3300, 32'h0000_04C9,  1'b0, EV_NONE,  BTN_NONE, 1'b0},
      '{2200, 32'h0000_2000,  1'b0, EV_NONE,  BTN_NONE, 1'b0},
      '{2200, 32'h0000_3000,  1'b0, EV_NONE,  BTN_NONE, 1'b0},
      '{2475, 32'h0000_4000,  1'b0, EV_NONE,  BTN_NONE, 1'b0},
      '{2475, 32'h0000_5000,  1'b0, EV_NONE,  BTN_NONE, 1'b0},
      '{1650, 32'h7FFF_6000,  1'b0, EV_NONE,  BTN_NONE, 1'b0},
      '{1650, 32'h8000_7000,  1'b0, EV_NONE,  BTN_NONE, 1'b0},
      '{0,    32'hFFFF_FFFF,  1'b0, EV_NONE,  BTN_NONE, 1'b0},
      '{0,    32'h0000_0000,  1'b0, EV_NONE,  BTN_NONE, 1'b0}
   };

   ladder_button_debounce_longpress #(
      .TICK_BITS (TICKW),
      .MV_BITS   (MVW)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_level_mv   (req_level_mv),
      .req_now_tick   (req_now_tick),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_event_kind (rsp_event_kind),
      .rsp_button     (rsp_button),
      .rsp_event_tick (rsp_event_tick),
      .rsp_activity   (rsp_activity)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic void reset_debouncer();
      ladder_mv[CSR_LEVEL_A]  = RST_LEVEL_A;
      ladder_mv[CSR_LEVEL_AB] = RST_LEVEL_AB;
      ladder_mv[CSR_LEVEL_B]  = RST_LEVEL_B;
      ladder_mv[CSR_LEVEL_BC] = RST_LEVEL_BC;
      ladder_mv[CSR_LEVEL_C]  = RST_LEVEL_C;
      ladder_mv[CSR_LEVEL_D]  = RST_LEVEL_D;
      settle_time  = RST_SETTLE;
      hold_time    = RST_HOLD;
      stable_btn   = BTN_NONE;
      stable_since = '0;
      long_sent    = 1'b0;
      trial_btn    = BTN_NONE;
      trial_since  = '0;
   endfunction

   function automatic btn_type decode_ladder(level_type mv);
      csr_index_type order [6];
      btn_type       btn_of [6];
      btn_type       best;
      int            best_dist;
      int            delta;
      // check order decides the winner on equal distance
      order  = '{CSR_LEVEL_AB, CSR_LEVEL_BC, CSR_LEVEL_D, CSR_LEVEL_C, CSR_LEVEL_B, CSR_LEVEL_A};
      btn_of = '{BTN_AB, BTN_BC, BTN_D, BTN_C, BTN_B, BTN_A};
      best      = BTN_NONE;
      best_dist = TOL_MV + 1;
      for (int i = 0; i < 6; i++) begin
         delta = int'(ladder_mv[order[i]]) - int'(mv);
         if (delta < 0) delta = -delta;
         if (delta < best_dist) begin
            best_dist = delta;
            best      = btn_of[i];
         end
      end
      return best;
   endfunction

   function automatic button_event_type debounce_step(level_type mv, tick_type now);
      button_event_type ev;
      btn_type          seen;
      tick_type         age;
      seen        = decode_ladder(mv);
      ev.kind     = EV_NONE;
      ev.activity = 1'b0;
      ev.tick     = now;
      age = now - trial_since;
      if (seen != trial_btn) begin
         trial_btn   = seen;
         trial_since = now;
         seen        = stable_btn;
      end else if (age < settle_time) begin
         seen = stable_btn;
      end
      age = now - stable_since;
      if (seen != stable_btn) begin
         ev.activity  = 1'b1;
         stable_since = now;
         long_sent    = 1'b0;
         stable_btn   = seen;
         if (seen != BTN_NONE) ev.kind = EV_PRESS;
      end else if (seen != BTN_NONE && !long_sent && age >= hold_time) begin
         long_sent = 1'b1;
         ev.kind   = EV_LONG;
      end
      ev.button = stable_btn;
      return ev;
   endfunction

   // everything sampled on the edge sees the values from before it
   always @(posedge clock) begin : check_results
      button_event_type got;
      button_event_type want;
      if (reset) begin
         reset_debouncer();
         event_queue.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.kind     = event_kind_type'(rsp_event_kind);
            got.button   = rsp_button;
            got.tick     = rsp_event_tick;
            got.activity = rsp_activity;
            if (event_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: result with no request pending: kind %0d button %0d tick %h",
                     $realtime, rsp_event_kind, rsp_button, rsp_event_tick);
            end else begin
               want = event_queue.pop_front();
               if (got.kind !== want.kind || got.button !== want.button ||
                   got.tick !== want.tick || got.activity !== want.activity) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display({"%0t: mismatch exp/act kind %0d/%0d button %0d/%0d",
                        " tick %h/%h act %b/%b"},
                        $realtime, want.kind, got.kind, want.button, got.button,
                        want.tick, got.tick, want.activity, got.activity);
               end
               if (want.kind == EV_PRESS) presses++;
               if (want.kind == EV_LONG) long_presses++;
               if (want.activity && want.button == BTN_NONE) releases++;
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_SETTLE: settle_time = csr_data;
               CSR_HOLD: hold_time = csr_data;
               default: ladder_mv[csr_index] = csr_data[LEVEL_BITS-1:0];
            endcase
         end
         if (req_valid && !req_stall) begin
            want = debounce_step(req_level_mv, req_now_tick);
            if (req_typed) want = req_typed_event;
            event_queue.push_back(want);
         end
      end
   end

   // receiver: quiet, light, heavy and periodic stall stretches in turn
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1'b1;
      case (stall_phase[9:8])
         2'd0: rsp_stall <= 1'b0;
         2'd1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2'd2: rsp_stall <= $urandom_range(0, 1);
         default: rsp_stall <= (stall_phase[2:0] >= 3'd5);
      endcase
   end

   task automatic send_sample(level_type mv, tick_type now, logic typed,
                              button_event_type typed_ev);
      int gap;
      req_valid       <= 1'b1;
      req_level_mv    <= mv;
      req_now_tick    <= now;
      req_typed       <= typed;
      req_typed_event <= typed_ev;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      samples_sent++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (event_queue.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic put_reg(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
   endtask

   task automatic write_settings(ladder_setting_type setting);
      level_type lv [6];
      time_type  st;
      time_type  hd;
      int        spacing;
      int        base;
      for (int i = 0; i < 6; i++) lv[i] = level_type'($urandom_range(0, 4095));
      st = time_type'($urandom_range(0, 100));
      hd = time_type'($urandom_range(0, 2000));
      case (setting)
         SET_RESET_LEVELS: begin
            lv[CSR_LEVEL_A]  = RST_LEVEL_A;
            lv[CSR_LEVEL_AB] = RST_LEVEL_AB;
            lv[CSR_LEVEL_B]  = RST_LEVEL_B;
            lv[CSR_LEVEL_BC] = RST_LEVEL_BC;
            lv[CSR_LEVEL_C]  = RST_LEVEL_C;
            lv[CSR_LEVEL_D]  = RST_LEVEL_D;
            st = time_type'($urandom_range(0, 40));
            hd = time_type'($urandom_range(0, 300));
         end
         SET_RAIL_LEVELS: begin
            // several levels share a rail, so ties resolve by check order
            lv = '{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095};
            st = '0;
            hd = '0;
         end
         SET_LONGEST_TIMES: begin
            st = '1;
            hd = '1;
         end
         SET_EVEN_SPACING: begin
            spacing = 2 * $urandom_range(1, 220);
            base = $urandom_range(0, 4095 - 5 * spacing);
            for (int i = 0; i < 6; i++) lv[i] = level_type'(base + i * spacing);
            st = time_type'($urandom_range(0, 30));
            hd = time_type'($urandom_range(0, 500));
         end
         default: ;
      endcase
      for (int i = CSR_LEVEL_A; i <= CSR_LEVEL_D; i++)
         put_reg(csr_index_type'(i), CSR_DATA_BITS'(lv[i]));
      put_reg(CSR_SETTLE, st);
      put_reg(CSR_HOLD, hd);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // mostly held levels with bounce at the start, some pure noise
   task automatic run_random(int count);
      tick_type now;
      int       n;
      int       pick;
      int       aim;
      int       mv;
      int       run_len;
      int       step;
      now = $urandom;
      n = 0;
      while (n < count) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            send_sample(level_type'($urandom_range(0, 4095)), $urandom, 1'b0, '0);
            n++;
         end else begin
            aim = $urandom_range(0, 6);
            if (aim == 6) aim = $urandom_range(0, 4095);
            else aim = ladder_mv[aim];
            if (pick == 1)
               aim = (int'(ladder_mv[$urandom_range(0, 5)]) +
                      int'(ladder_mv[$urandom_range(0, 5)])) / 2;
            if ($urandom_range(0, 7) == 0) now = 32'hFFFF_FFFF - $urandom_range(0, 200);
            run_len = $urandom_range(2, 12);
            for (int k = 0; k < run_len && n < count; k++) begin
               if (k < 2 && $urandom_range(0, 1) == 1)
                  mv = aim + int'($urandom_range(0, 480)) - 240;
               else
                  mv = aim + int'($urandom_range(0, 60)) - 30;
               if (mv < 0) mv = 0;
               if (mv > 4095) mv = 4095;
               if ($urandom_range(0, 4) == 0)
                  step = int'(hold_time) + $urandom_range(0, 8);
               else
                  step = $urandom_range(0, int'(settle_time) + int'(hold_time) / 4 + 2);
               now = now + tick_type'(step);
               send_sample(level_type'(mv), now, 1'b0, '0);
               n++;
            end
         end
      end
   endtask

   initial begin
      button_event_type typed_ev;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (opening_rows[i]) begin
         typed_ev.kind     = opening_rows[i].kind;
         typed_ev.button   = opening_rows[i].button;
         typed_ev.tick     = opening_rows[i].tick;
         typed_ev.activity = opening_rows[i].activity;
         send_sample(level_type'(opening_rows[i].level), opening_rows[i].tick,
            opening_rows[i].typed, typed_ev);
      end
      wait_drained();
      foreach (phase_plan[p]) begin
         write_settings(phase_plan[p]);
         run_random(PHASE_ITEMS);
         wait_drained();
      end
      repeat (4) @(posedge clock);
      $display("%0d samples over %0d ladder settings, including rail levels and longest times",
         samples_sent, settings_used);
      $display("%0d presses, %0d long presses, %0d releases checked, %0d mismatches",
         presses, long_presses, releases, mismatches);
      if (mismatches == 0 && event_queue.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
